[src/mcpwm_pkg.sv]
// Shared constants, codes and types for the multi-channel PWM with breathing ramp.
package mcpwm_pkg;

	localparam int NUM_CHANNELS = 12;
	localparam int COUNT_BITS   = 16;
	localparam int CNT_W        = COUNT_BITS + 1;
	localparam int CH_BITS      = 4;
	localparam int ACT_BITS     = 3;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_W   = 16;

	localparam logic [ACT_BITS-1:0] ACT_TICK = 3'd0;
	localparam logic [ACT_BITS-1:0] ACT_INIT = 3'd1;
	localparam logic [ACT_BITS-1:0] ACT_SET  = 3'd2;
	localparam logic [ACT_BITS-1:0] ACT_STOP = 3'd3;
	localparam logic [ACT_BITS-1:0] ACT_RAMP = 3'd4;

	localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_TOP    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_PERIOD = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_CHAN   = 2'd2;

	localparam logic [COUNT_BITS-1:0] RAMP_TOP_RST    = 16'd10;
	localparam logic [COUNT_BITS-1:0] RAMP_PERIOD_RST = 16'd10;
	localparam logic [CH_BITS-1:0]    RAMP_CHAN_RST   = 4'd0;

	typedef struct packed {
		logic                  tick;
		logic                  init;
		logic                  set;
		logic                  stop;
		logic                  enable;
		logic [COUNT_BITS-1:0] period;
		logic [COUNT_BITS-1:0] duty;
	} chan_cmd_t;

	typedef struct packed {
		logic pin_d;
		logic pin_q;
		logic started;
	} chan_stat_t;

endpackage

[src/mcpwm_chan.sv]
// One PWM channel: counter, period, duty, run and started flags, and its pin.
module mcpwm_chan import mcpwm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  chan_cmd_t  cmd,
	output chan_stat_t stat
);

	logic [CNT_W-1:0]      count_q;
	logic [COUNT_BITS-1:0] period_q;
	logic [COUNT_BITS-1:0] duty_q;
	logic                  en_q;
	logic                  started_q;
	logic                  pin_q;

	logic [CNT_W-1:0] count_inc;
	logic [CNT_W-1:0] count_d;
	logic             pin_d;

	assign count_inc = count_q + CNT_W'(1);

	always_comb begin
		count_d = count_q;
		pin_d   = pin_q;
		if (cmd.tick && started_q) begin
			if (!en_q) begin
				count_d = '0;
				pin_d   = 1'b0;
			end else if (count_inc > {1'b0, period_q}) begin
				count_d = '0;
			end else begin
				count_d = count_inc;
				pin_d   = (count_inc <= {1'b0, duty_q});
			end
		end else if (cmd.init) begin
			count_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			period_q  <= '0;
			duty_q    <= '0;
			en_q      <= 1'b0;
			started_q <= 1'b0;
			pin_q     <= 1'b0;
		end else begin
			count_q <= count_d;
			pin_q   <= pin_d;
			if (cmd.init) begin
				en_q      <= cmd.enable;
				started_q <= 1'b1;
			end else if (cmd.stop) begin
				en_q <= 1'b0;
			end
			if (cmd.init || cmd.set) begin
				period_q <= cmd.period;
				duty_q   <= cmd.duty;
			end
		end
	end

	assign stat.pin_d   = pin_d;
	assign stat.pin_q   = pin_q;
	assign stat.started = started_q;

endmodule

[src/mcpwm_ramp.sv]
// Triangle breathing ramp: level register, direction flag and channel write strobe.
module mcpwm_ramp import mcpwm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [COUNT_BITS-1:0] ramp_top,
	output logic [COUNT_BITS-1:0] level_d,
	output logic [COUNT_BITS-1:0] level_q,
	output logic                  wr
);

	logic falling_q;
	logic falling_d;

	always_comb begin
		level_d   = level_q;
		falling_d = falling_q;
		wr        = 1'b0;
		if (step) begin
			if (!falling_q) begin
				if (level_q < ramp_top) begin
					level_d = level_q + COUNT_BITS'(1);
					wr      = 1'b1;
				end else begin
					falling_d = 1'b1;
				end
			end else begin
				if (level_q != '0) begin
					level_d = level_q - COUNT_BITS'(1);
					wr      = 1'b1;
				end else begin
					falling_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '0;
			falling_q <= 1'b0;
		end else begin
			level_q   <= level_d;
			falling_q <= falling_d;
		end
	end

endmodule

[src/multi_channel_pwm_with_breath_ramp.sv]
// Top level of the twelve-channel counter PWM with a breathing ramp.
//
//   Port group   Direction  Handshake          Content
//   in_*         input      in_valid/in_ready  action, channel, period, duty, enable
//   out_*        output     out_valid/out_ready pin_mask, ramp_level, result_code
//   cfg_*        input      cfg_we only        ramp_top, ramp_period, ramp_channel
//
// A beat is registered on entry and processed from that input register into the result
// register; one beat is accepted every cycle while the result is not stalled.
// Reset clears every channel, the ramp and the configuration to their defaults.
// A stalled result holds the processing stage, which holds the input register.
module multi_channel_pwm_with_breath_ramp import mcpwm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [ACT_BITS-1:0]     action,
	input  logic [CH_BITS-1:0]      channel,
	input  logic [COUNT_BITS-1:0]   period,
	input  logic [COUNT_BITS-1:0]   duty,
	input  logic                    enable,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [NUM_CHANNELS-1:0] pin_mask,
	output logic [COUNT_BITS-1:0]   ramp_level,
	output logic                    result_code,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	logic                  valid_s1;
	logic [ACT_BITS-1:0]   action_s1;
	logic [CH_BITS-1:0]    channel_s1;
	logic [COUNT_BITS-1:0] period_s1;
	logic [COUNT_BITS-1:0] duty_s1;
	logic                  enable_s1;

	logic                    valid_s2;
	logic [NUM_CHANNELS-1:0] pin_mask_s2;
	logic [COUNT_BITS-1:0]   ramp_level_s2;
	logic                    result_code_s2;

	logic [COUNT_BITS-1:0] ramp_top_q;
	logic [COUNT_BITS-1:0] ramp_period_q;
	logic [CH_BITS-1:0]    ramp_chan_q;

	logic                  advance;
	logic                  fire;
	logic                  ramp_wr;
	logic [COUNT_BITS-1:0] ramp_d;
	logic [COUNT_BITS-1:0] ramp_q;

	chan_cmd_t               cmd  [NUM_CHANNELS];
	chan_stat_t              stat [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] pin_d_vec;
	logic [NUM_CHANNELS-1:0] pin_q_vec;
	logic [NUM_CHANNELS-1:0] code_vec;

	assign advance  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_top_q    <= RAMP_TOP_RST;
			ramp_period_q <= RAMP_PERIOD_RST;
			ramp_chan_q   <= RAMP_CHAN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RAMP_TOP:    ramp_top_q    <= cfg_data[COUNT_BITS-1:0];
				CFG_RAMP_PERIOD: ramp_period_q <= cfg_data[COUNT_BITS-1:0];
				CFG_RAMP_CHAN:   ramp_chan_q   <= cfg_data[CH_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1  <= action;
			channel_s1 <= channel;
			period_s1  <= period;
			duty_s1    <= duty;
			enable_s1  <= enable;
		end
	end

	mcpwm_ramp u_ramp (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (fire && action_s1 == ACT_RAMP),
		.ramp_top (ramp_top_q),
		.level_d  (ramp_d),
		.level_q  (ramp_q),
		.wr       (ramp_wr)
	);

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
		logic hit;
		logic ramp_hit;

		assign hit      = (channel_s1 == CH_BITS'(i));
		assign ramp_hit = ramp_wr && (ramp_chan_q == CH_BITS'(i));

		always_comb begin
			cmd[i].tick   = fire && action_s1 == ACT_TICK;
			cmd[i].init   = fire && action_s1 == ACT_INIT && hit;
			cmd[i].set    = (fire && action_s1 == ACT_SET && hit) || ramp_hit;
			cmd[i].stop   = fire && action_s1 == ACT_STOP && hit;
			cmd[i].enable = enable_s1;
			cmd[i].period = (action_s1 == ACT_RAMP) ? ramp_period_q : period_s1;
			cmd[i].duty   = (action_s1 == ACT_RAMP) ? ramp_d : duty_s1;
		end

		mcpwm_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd[i]),
			.stat   (stat[i])
		);

		assign pin_d_vec[i] = stat[i].pin_d;
		assign pin_q_vec[i] = stat[i].pin_q;
		assign code_vec[i]  = cmd[i].init && stat[i].started;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pin_mask_s2    <= pin_d_vec;
			ramp_level_s2  <= ramp_d;
			result_code_s2 <= |code_vec;
		end
	end

	assign out_valid   = valid_s2;
	assign pin_mask    = pin_mask_s2;
	assign ramp_level  = ramp_level_s2;
	assign result_code = result_code_s2;

	a_code_only_init: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && action_s1 != ACT_INIT) |=> !result_code)
		else $error("Result code set by a beat that is not an init.");

	a_ramp_matches: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ramp_level == ramp_q)
		else $error("Presented ramp level differs from the ramp register.");

	a_pins_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> pin_mask == pin_q_vec)
		else $error("Presented pin mask differs from the channel pins.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("Input stalled while the result stage is empty.");

endmodule
